@@ rtl/srv_pkg.sv @@
`timescale 1ns / 1ps
package srv_pkg;

  localparam logic [1:0] REQ_SET_MEAN = 2'd0;
  localparam logic [1:0] REQ_ADD      = 2'd1;
  localparam logic [1:0] REQ_READ     = 2'd2;

  localparam int CNT_W  = 20;
  localparam int MEAN_W = 32;
  localparam int SUM_W  = 64;
  localparam int WORD_W = 1 + CNT_W + SUM_W + MEAN_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] row_index;
    logic [31:0] value;
  } srv_in_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [63:0] variance;
    logic        clamped;
  } srv_out_t;

  typedef struct packed {
    logic             flag;
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
    logic [MEAN_W-1:0] mean;
  } srv_word_t;

endpackage

@@ rtl/srv_ram.sv @@
`timescale 1ns / 1ps
module srv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/srv_divider.sv @@
`timescale 1ns / 1ps
module srv_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [19:0] rem_in,
  input  logic [63:0] num_lo,
  input  logic [19:0] divisor,
  output logic        done,
  output logic [63:0] quot
);
  logic [20:0] rem_r, rem_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic [19:0] d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [20:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[19:0], sh_r[63]};
    if (start) begin
      rem_nxt  = {1'b0, rem_in};
      sh_nxt   = num_lo;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift the next dividend bit in, quotient bit out at the bottom
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        sh_nxt  = {sh_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        sh_nxt  = {sh_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = sh_r;
endmodule

@@ rtl/sparse_row_variance_core.sv @@
`timescale 1ns / 1ps
// Set-mean writes the row directly; add reads the row, squares the deviation and writes it back;
// read goes through row read, square, two partial products, a sum and a 1-bit-per-cycle divider.
// One item in flight: in_ready is low until the block is back in idle.
// Reset: synchronous active-low rst_n clears control and sets the column count n_r to 2.
// The row memory is not cleared; a row holds garbage until its set-mean beat.
module sparse_row_variance_core #(
  parameter int NUM_ROWS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  srv_pkg::srv_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output srv_pkg::srv_out_t out_data,
  input  logic             cfg_wr_en,
  input  logic [19:0]      cfg_wr_data
);
  import srv_pkg::*;

  localparam int AW = NUM_ROWS > 1 ? $clog2(NUM_ROWS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_ADD   = 4'd3;
  localparam logic [3:0] S_M0    = 4'd4;
  localparam logic [3:0] S_M1    = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_DIVGO = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [19:0] n_r;
  logic        in_acc, in_range;
  logic [1:0]  req_r;
  logic [11:0] row_r;
  logic [31:0] val_r;

  srv_word_t   rd_word, wr_word;
  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr, in_addr;

  logic [31:0] mean_r, dev_r;
  logic [63:0] sum_r, sq_r, var_r;
  logic [19:0] cnt_r, rem_r, dvs_r;
  logic        flag_r, sat_r;
  logic [51:0] p0_r, p1_r;
  logic [84:0] total_r;
  logic [64:0] add_s;

  logic        div_start, div_done;
  logic [63:0] div_q;

  srv_out_t    out_r;
  logic        out_valid_r;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_range = (32'(in_data.row_index) < 32'(NUM_ROWS));
  assign in_addr  = AW'({4'b0, in_data.row_index});
  assign add_s    = {1'b0, sum_r} + {1'b0, sq_r};

  always_comb begin
    ram_re    = in_acc && in_range &&
                (in_data.req_type == REQ_ADD || in_data.req_type == REQ_READ);
    ram_we    = 1'b0;
    ram_waddr = in_addr;
    wr_word   = '{flag: 1'b0, cnt: '0, sum: '0, mean: in_data.value};
    if (in_acc && in_range && in_data.req_type == REQ_SET_MEAN) begin
      ram_we = 1'b1;
    end else if (state_r == S_ADD) begin
      ram_we       = 1'b1;
      ram_waddr    = AW'({4'b0, row_r});
      wr_word.mean = mean_r;
      wr_word.sum  = add_s[64] ? {SUM_W{1'b1}} : add_s[63:0];
      wr_word.cnt  = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 20'd1;
      wr_word.flag = flag_r | add_s[64] | (cnt_r == COUNT_MAX);
    end
  end

  srv_ram #(.WIDTH(WORD_W), .DEPTH(NUM_ROWS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_word),
    .re    (ram_re),
    .raddr (in_addr),
    .rdata (rd_word)
  );

  assign div_start = (state_r == S_DIVGO) && (total_r[84:64] < {1'b0, dvs_r});

  srv_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .rem_in  (total_r[83:64]),
    .num_lo  (total_r[63:0]),
    .divisor (dvs_r),
    .done    (div_done),
    .quot    (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_range &&
            (in_data.req_type == REQ_ADD || in_data.req_type == REQ_READ)) begin
          state_nxt = S_RD;
        end
      end
      S_RD:    state_nxt = S_SQ;
      S_SQ:    state_nxt = (req_r == REQ_ADD) ? S_ADD : S_M0;
      S_ADD:   state_nxt = S_IDLE;
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_SUM;
      S_SUM:   state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = div_start ? S_DIV : S_OUT;
      S_DIV:   state_nxt = div_done ? S_OUT : S_DIV;
      S_OUT:   state_nxt = (!out_valid_r || out_ready) ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= 20'd2;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        n_r <= cfg_wr_data;
      end
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (in_acc) begin
      req_r <= in_data.req_type;
      row_r <= in_data.row_index;
      val_r <= in_data.value;
    end

    case (state_r)
      S_RD: begin
        mean_r <= rd_word.mean;
        sum_r  <= rd_word.sum;
        cnt_r  <= rd_word.cnt;
        flag_r <= rd_word.flag;
        if (req_r == REQ_ADD) begin
          dev_r <= (val_r >= rd_word.mean) ? val_r - rd_word.mean : rd_word.mean - val_r;
        end else begin
          dev_r <= rd_word.mean;
        end
        // zero entries beyond n drop out; a degenerate n divides by one
        rem_r <= (rd_word.cnt > n_r) ? 20'd0 : n_r - rd_word.cnt;
        dvs_r <= (n_r < 20'd2) ? 20'd1 : n_r - 20'd1;
        sat_r <= rd_word.flag | (rd_word.cnt > n_r) | (n_r < 20'd2);
      end
      S_SQ:  sq_r <= 64'(dev_r) * 64'(dev_r);
      S_M0:  p0_r <= 52'(rem_r) * 52'(sq_r[31:0]);
      S_M1:  p1_r <= 52'(rem_r) * 52'(sq_r[63:32]);
      S_SUM: total_r <= 85'(p0_r) + (85'(p1_r) << 32) + 85'(sum_r);
      S_DIVGO: begin
        if (!div_start) begin
          var_r <= {64{1'b1}};
          sat_r <= 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          var_r <= div_q;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_r.out_row  <= row_r;
          out_r.variance <= var_r;
          out_r.clamped  <= sat_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_ADD))
    else $error("row write outside set-mean or add");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider done outside wait state");
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result beat without read completion");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> state_r == S_DIV)
    else $error("divider started without wait");
endmodule

@@ test/sparse_row_variance_core_tb.sv @@
`timescale 1ns / 1ps
module sparse_row_variance_core_tb;
  import srv_pkg::*;

  localparam int NROWS = 4096;
  localparam logic [63:0] ALL_ONES64 = {64{1'b1}};
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  srv_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  srv_out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [19:0] cfg_wr_data = '0;

  sparse_row_variance_core #(.NUM_ROWS(NROWS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [19:0] col_count;
  logic [31:0] row_mean [NROWS];
  logic [63:0] row_sq_sum [NROWS];
  logic [19:0] row_nnz [NROWS];
  logic row_sat [NROWS];
  bit row_live [NROWS];

  srv_in_t pending_beats[$];
  srv_out_t expected_variances[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int idle_cycles = 0;
  int beats_in = 0;
  int beats_out = 0;
  int reads_sent = 0;
  int sat_seen = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  function automatic void predict_variance(input srv_in_t b);
    logic [31:0] dev;
    logic [63:0] sq, s;
    logic [127:0] total, quot;
    logic [19:0] rem, divisor;
    bit sat;
    srv_out_t r;
    if (b.row_index >= NROWS) return;
    case (b.req_type)
      REQ_SET_MEAN: begin
        row_mean[b.row_index] = b.value;
        row_sq_sum[b.row_index] = '0;
        row_nnz[b.row_index] = '0;
        row_sat[b.row_index] = 1'b0;
      end
      REQ_ADD: begin
        dev = (b.value >= row_mean[b.row_index]) ? b.value - row_mean[b.row_index]
                                                 : row_mean[b.row_index] - b.value;
        sq = 64'(dev) * 64'(dev);
        s = row_sq_sum[b.row_index] + sq;
        if (s < sq) begin
          s = ALL_ONES64;
          row_sat[b.row_index] = 1'b1;
        end
        row_sq_sum[b.row_index] = s;
        if (row_nnz[b.row_index] == COUNT_MAX) row_sat[b.row_index] = 1'b1;
        else row_nnz[b.row_index] = row_nnz[b.row_index] + 20'd1;
      end
      REQ_READ: begin
        sat = row_sat[b.row_index];
        if (row_nnz[b.row_index] > col_count) begin
          rem = '0;
          sat = 1'b1;
        end else begin
          rem = col_count - row_nnz[b.row_index];
        end
        if (col_count < 20'd2) begin
          divisor = 20'd1;
          sat = 1'b1;
        end else begin
          divisor = col_count - 20'd1;
        end
        total = 128'(rem) * (128'(row_mean[b.row_index]) * 128'(row_mean[b.row_index]))
                + 128'(row_sq_sum[b.row_index]);
        quot = total / 128'(divisor);
        r.out_row = b.row_index;
        if (quot[127:64] != 0) begin
          r.variance = ALL_ONES64;
          sat = 1'b1;
        end else begin
          r.variance = quot[63:0];
        end
        r.clamped = sat;
        expected_variances.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_variance(in_data);
      beats_in++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    srv_out_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (expected_variances.size() == 0) begin
        report_mismatch("unexpected result row", 64'(out_data.out_row), 64'd0);
      end else begin
        want = expected_variances.pop_front();
        if (want.clamped) sat_seen++;
        if (out_data.out_row !== want.out_row)
          report_mismatch("out_row", 64'(out_data.out_row), 64'(want.out_row));
        if (out_data.variance !== want.variance)
          report_mismatch("variance", out_data.variance, want.variance);
        if (out_data.clamped !== want.clamped)
          report_mismatch("clamped", 64'(out_data.clamped), 64'(want.clamped));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_beat(input logic [1:0] kind, input int row, input logic [31:0] v);
    srv_in_t b;
    b.req_type = kind;
    b.row_index = 12'(row);
    b.value = v;
    if (kind == REQ_SET_MEAN) row_live[row] = 1'b1;
    if (kind == REQ_READ) reads_sent++;
    pending_beats.push_back(b);
  endtask

  task automatic drain_then_config(input logic [19:0] n);
    wait (pending_beats.size() == 0);
    @(posedge clk);
    while (in_valid || expected_variances.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    col_count = n;
    cfg_wr_en <= 1'b0;
  endtask

  // random phase: mostly well-formed row sessions, some stray traffic
  task automatic random_phase(input int count);
    int row, k, nadd;
    logic [31:0] m;
    k = 0;
    while (k < count) begin
      row = (($urandom_range(9) == 0) ? $urandom_range(NROWS - 1) : $urandom_range(15));
      if (!row_live[row] || $urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: m = $urandom;
          1: m = 32'($urandom_range(255)) << 16;
          2: m = '1;
          default: m = $urandom_range(65535);
        endcase
        push_beat(REQ_SET_MEAN, row, m);
        k++;
      end
      nadd = $urandom_range(6);
      repeat (nadd) begin
        push_beat(REQ_ADD, row, ($urandom_range(4) == 0) ? 32'($urandom) :
                  row_mean[row] ^ 32'($urandom_range(1 << 18)));
        k++;
      end
      if ($urandom_range(9) == 0) begin
        push_beat(REQ_UNKNOWN, $urandom_range(NROWS - 1), $urandom);
        k++;
      end
      push_beat(REQ_READ, row, $urandom);
      k++;
    end
  endtask

  initial begin
    int i;
    col_count = 20'd2;
    for (i = 0; i < NROWS; i++) begin
      row_mean[i] = '0;
      row_sq_sum[i] = '0;
      row_nnz[i] = '0;
      row_sat[i] = 1'b0;
      row_live[i] = 1'b0;
    end
    send_idle_pct = 18;
    recv_idle_pct = 59;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every request, ignored codes, sum overflow
    push_beat(REQ_SET_MEAN, 0, 32'h0001_0000);
    push_beat(REQ_ADD, 0, 32'h0003_0000);
    push_beat(REQ_READ, 0, '0);
    push_beat(REQ_SET_MEAN, NROWS - 1, '1);
    push_beat(REQ_ADD, NROWS - 1, '0);
    push_beat(REQ_ADD, NROWS - 1, '0);
    push_beat(REQ_ADD, NROWS - 1, '0);
    push_beat(REQ_READ, NROWS - 1, '1);
    push_beat(REQ_UNKNOWN, 5, 32'hA5A5_5A5A);
    push_beat(REQ_SET_MEAN, 7, '0);
    push_beat(REQ_READ, 7, '0);
    push_beat(REQ_SET_MEAN, 1, 32'h8000_0000);
    push_beat(REQ_ADD, 1, 32'h7FFF_FFFF);
    push_beat(REQ_READ, 1, '0);
    drain_then_config(20'd1);
    // small n and count above n
    push_beat(REQ_READ, 0, '0);
    push_beat(REQ_READ, NROWS - 1, '0);
    drain_then_config(20'd0);
    push_beat(REQ_READ, 1, '0);
    drain_then_config(20'hFFFFF);
    push_beat(REQ_READ, 0, '0);
    push_beat(REQ_READ, NROWS - 1, '0);

    random_phase(500);
    drain_then_config(20'd16);

    // hold the receiver long enough to fill the block and stall the input
    push_beat(REQ_READ, 0, '0);
    push_beat(REQ_READ, 1, '0);
    push_beat(REQ_READ, 7, '0);
    push_beat(REQ_ADD, 7, 32'h0000_1234);
    recv_hold = 1'b1;
    repeat (600) @(posedge clk);
    recv_hold = 1'b0;
    send_idle_pct = 59;
    recv_idle_pct = 18;
    random_phase(550);
    drain_then_config(20'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(300);
    drain_then_config(20'd2);
    random_phase(250);

    wait (pending_beats.size() == 0);
    @(posedge clk);
    while (in_valid || expected_variances.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d accepted beats, %0d reads queued, %0d results checked",
             beats_in, reads_sent, beats_out);
    $display("Saturated or clamped results: %0d, column counts 0 to 2^20-1", sat_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/srv_pkg.sv
rtl/srv_ram.sv
rtl/srv_divider.sv
rtl/sparse_row_variance_core.sv
test/sparse_row_variance_core_tb.sv
